// ----- src/sac_pkg.sv -----
// Shared constants and types for the set-associative LRU cache simulator.
`timescale 1ns / 1ps

package sac_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 32;

  localparam int CNT_W      = 32;
  localparam int SET_BITS_W = 3;
  localparam int BLK_BITS_W = 5;
  localparam int WAYS_W     = 4;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST   = 3'd0;
  localparam logic [BLK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]     WAYS_RST       = 4'd1;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_flags_t;

endpackage

// ----- src/sac_mem.sv -----
// Set memory: one row per set, synchronous write, registered read.
`timescale 1ns / 1ps

module sac_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 288
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/sac_lookup.sv -----
// Tag match, victim choice and LRU age update for one set row.
`timescale 1ns / 1ps

module sac_lookup #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32,
  parameter int AGE_WIDTH  = 3
) (
  input  logic [sac_pkg::WAYS_W-1:0]                      ways,
  input  logic [ADDR_WIDTH-1:0]                           tag,
  input  logic [MAX_WAYS*(1+AGE_WIDTH+ADDR_WIDTH)-1:0]    row_in,
  output logic [MAX_WAYS*(1+AGE_WIDTH+ADDR_WIDTH)-1:0]    row_out,
  output sac_pkg::lookup_flags_t                          flags
);

  localparam int LINE_W = 1 + AGE_WIDTH + ADDR_WIDTH;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = AGE_WIDTH'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0][LINE_W-1:0]     lines;
  logic [MAX_WAYS-1:0][LINE_W-1:0]     lines_next;
  logic [MAX_WAYS-1:0]                 in_use;
  logic [MAX_WAYS-1:0]                 vld;
  logic [MAX_WAYS-1:0]                 match;
  logic [MAX_WAYS-1:0]                 empty;
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  age;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tg;
  logic [NW_W-1:0]                     n_ways;
  logic [WAY_W-1:0]                    hit_way;
  logic [WAY_W-1:0]                    empty_way;
  logic [WAY_W-1:0]                    old_way;
  logic [WAY_W-1:0]                    way;
  logic [AGE_WIDTH-1:0]                best;
  logic [AGE_WIDTH:0]                  old_age;
  logic                                hit_any;
  logic                                empty_any;

  assign lines = row_in;

  always_comb begin
    if (ways == '0) begin
      n_ways = NW_W'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      n_ways = NW_W'(MAX_WAYS);
    end else begin
      n_ways = NW_W'(ways);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_WAYS; k++) begin
      in_use[k] = NW_W'(k) < n_ways;
      vld[k]    = lines[k][LINE_W-1];
      age[k]    = lines[k][ADDR_WIDTH +: AGE_WIDTH];
      tg[k]     = lines[k][ADDR_WIDTH-1:0];
      match[k]  = in_use[k] && vld[k] && (tg[k] == tag);
      empty[k]  = in_use[k] && !vld[k];
    end
  end

  // lowest matching / lowest empty way
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int k = MAX_WAYS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_way = WAY_W'(k);
      end
      if (empty[k]) begin
        empty_way = WAY_W'(k);
      end
    end
  end

  // oldest way, first on ties
  always_comb begin
    best    = '0;
    old_way = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && age[k] > best) begin
        best    = age[k];
        old_way = WAY_W'(k);
      end
    end
  end

  assign hit_any   = |match;
  assign empty_any = |empty;
  assign way       = hit_any ? hit_way : (empty_any ? empty_way : old_way);
  assign old_age   = vld[way] ? {1'b0, age[way]} : ({1'b0, AGE_MAX} + 1'b1);

  always_comb begin
    lines_next = lines;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && WAY_W'(k) != way && vld[k] && ({1'b0, age[k]} < old_age) &&
          age[k] < AGE_MAX) begin
        lines_next[k][ADDR_WIDTH +: AGE_WIDTH] = age[k] + 1'b1;
      end
    end
    lines_next[way] = {1'b1, {AGE_WIDTH{1'b0}}, tag};
  end

  assign row_out       = lines_next;
  assign flags.hit     = hit_any;
  assign flags.evicted = !hit_any && !empty_any;

endmodule

// ----- src/set_assoc_lru_cache_sim.sv -----
// Top level: set-associative LRU cache simulator with access and config channels.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------
//   in      | in_valid / in_ready    | action, address
//   out     | out_valid / out_ready  | hit, evicted, last, hits_total,
//           |                        | misses_total, evictions_total
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Load or store: the set row is read, then updated and written back.
// Modify: a second lookup follows and works on the forwarded updated row.
// Rate is set by the read, then update and write-back of one set row per lookup.
// After reset a clearing pass zeroes all 2^MAX_SET_BITS rows (64 by default) of the
// set memory; in_ready stays low during it, cfg writes are taken.
// A stalled result holds the lookup; the next one waits for the output register.
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = sac_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = sac_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sac_pkg::ACTION_W-1:0]     action,
  input  logic [ADDR_WIDTH-1:0]            address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic                             evicted,
  output logic                             last,
  output logic [sac_pkg::CNT_W-1:0]        hits_total,
  output logic [sac_pkg::CNT_W-1:0]        misses_total,
  output logic [sac_pkg::CNT_W-1:0]        evictions_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W  = 1 + AGE_W + ADDR_WIDTH;
  localparam int ROW_W   = MAX_WAYS * LINE_W;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH   = 1 << MAX_SET_BITS;
  localparam int SHIFT_W = $clog2(MAX_SET_BITS + 32);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]                         state;
  logic [SET_W-1:0]                   clr_addr;
  logic [sac_pkg::SET_BITS_W-1:0]     set_bits;
  logic [sac_pkg::BLK_BITS_W-1:0]     block_bits;
  logic [sac_pkg::WAYS_W-1:0]         ways;
  logic [SET_W-1:0]                   cur_set;
  logic [ADDR_WIDTH-1:0]              cur_tag;
  logic                               modify;
  logic                               second;
  logic [ROW_W-1:0]                   fwd_row;
  logic [sac_pkg::CNT_W-1:0]          hits_cnt;
  logic [sac_pkg::CNT_W-1:0]          misses_cnt;
  logic [sac_pkg::CNT_W-1:0]          evict_cnt;

  logic [SHIFT_W-1:0]                 sb;
  logic [SHIFT_W-1:0]                 shift_sum;
  logic [ADDR_WIDTH-1:0]              addr_shift;
  logic [SET_W-1:0]                   set_mask;
  logic [SET_W-1:0]                   set_calc;
  logic [ADDR_WIDTH-1:0]              tag_calc;

  logic                               in_xact;
  logic                               look_fire;
  logic                               mem_we;
  logic [SET_W-1:0]                   mem_waddr;
  logic [ROW_W-1:0]                   mem_wdata;
  logic                               mem_re;
  logic [ROW_W-1:0]                   rd_row;
  logic [ROW_W-1:0]                   row_sel;
  logic [ROW_W-1:0]                   row_new;
  sac_pkg::lookup_flags_t             flags;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE);
  assign in_xact    = in_valid && in_ready;
  assign look_fire  = (state == ST_LOOK) && (!out_valid || out_ready);

  assign hits_total      = hits_cnt;
  assign misses_total    = misses_cnt;
  assign evictions_total = evict_cnt;

  // address split
  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb = SHIFT_W'(MAX_SET_BITS);
    end else begin
      sb = SHIFT_W'(set_bits);
    end
  end

  assign shift_sum  = sb + SHIFT_W'(block_bits);
  assign addr_shift = address >> block_bits;
  assign set_mask   = ~({SET_W{1'b1}} << sb);
  assign set_calc   = addr_shift[SET_W-1:0] & set_mask;
  assign tag_calc   = address >> shift_sum;

  assign mem_re = in_xact && (action != sac_pkg::ACT_NONE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_set;
    mem_wdata = row_new;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (look_fire) begin
      mem_we = 1'b1;
    end
  end

  sac_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (set_calc),
    .rd_data (rd_row)
  );

  assign row_sel = second ? fwd_row : rd_row;

  sac_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .AGE_WIDTH  (AGE_W)
  ) u_lookup (
    .ways    (ways),
    .tag     (cur_tag),
    .row_in  (row_sel),
    .row_out (row_new),
    .flags   (flags)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= sac_pkg::SET_BITS_RST;
      block_bits <= sac_pkg::BLOCK_BITS_RST;
      ways       <= sac_pkg::WAYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sac_pkg::REG_SET_BITS:   set_bits   <= cfg_data[sac_pkg::SET_BITS_W-1:0];
        sac_pkg::REG_BLOCK_BITS: block_bits <= cfg_data;
        sac_pkg::REG_WAYS:       ways       <= cfg_data[sac_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      modify   <= 1'b0;
      second   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SET_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (mem_re) begin
            modify <= (action == sac_pkg::ACT_MODIFY);
            second <= 1'b0;
            state  <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (look_fire) begin
            if (modify && !second) begin
              second <= 1'b1;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      cur_set <= set_calc;
      cur_tag <= tag_calc;
    end
    if (look_fire) begin
      fwd_row <= row_new;
    end
  end

  // results and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hits_cnt   <= '0;
      misses_cnt <= '0;
      evict_cnt  <= '0;
    end else begin
      if (look_fire) begin
        out_valid <= 1'b1;
        if (flags.hit) begin
          hits_cnt <= (hits_cnt == '1) ? hits_cnt : hits_cnt + 1'b1;
        end else begin
          misses_cnt <= (misses_cnt == '1) ? misses_cnt : misses_cnt + 1'b1;
        end
        if (flags.evicted) begin
          evict_cnt <= (evict_cnt == '1) ? evict_cnt : evict_cnt + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_fire) begin
      hit     <= flags.hit;
      evicted <= flags.evicted;
      last    <= !(modify && !second);
    end
  end

`ifndef NO_ASSERTIONS
  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |-> (state == ST_LOOK && second && modify))
    else $error("non-final result without pending second lookup");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hits_cnt >= $past(hits_cnt)))
    else $error("hit total decreased");

  a_miss_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (misses_cnt >= $past(misses_cnt)))
    else $error("miss total decreased");

  a_evict_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (evict_cnt != '0 && !hit))
    else $error("eviction result inconsistent with totals");
`endif

endmodule

// ----- sim/tb_set_assoc_lru_cache_sim.sv -----
// Self-checking testbench for set_assoc_lru_cache_sim: LRU predictor, scoreboard, random traffic.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim;

  localparam int NUM_LINES    = (1 << sac_pkg::MAX_SET_BITS_DEF) * sac_pkg::MAX_WAYS_DEF;
  localparam int AGE_TOP      = sac_pkg::MAX_WAYS_DEF - 1;
  localparam int ACT_W        = sac_pkg::ACTION_W;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 170;
  localparam int SETTLE_CYC   = 8;
  localparam int HOLD_CYC     = 400;
  localparam int TIMEOUT_NS   = 6_000_000;
  localparam logic [sac_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                      hit;
    logic                      evicted;
    logic                      last;
    logic [sac_pkg::CNT_W-1:0] hits;
    logic [sac_pkg::CNT_W-1:0] misses;
    logic [sac_pkg::CNT_W-1:0] evictions;
  } outcome_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_t;

  class cache_scoreboard;
    bit                                 way_used[NUM_LINES];
    logic [31:0]                        way_tag[NUM_LINES];
    int                                 way_rank[NUM_LINES];
    logic [sac_pkg::SET_BITS_W-1:0]     reg_set_bits;
    logic [sac_pkg::BLK_BITS_W-1:0]     reg_block_bits;
    logic [sac_pkg::WAYS_W-1:0]         reg_ways;
    logic [sac_pkg::CNT_W-1:0]          hit_total;
    logic [sac_pkg::CNT_W-1:0]          miss_total;
    logic [sac_pkg::CNT_W-1:0]          evict_total;
    outcome_t                           awaited[$];
    int                                 errors;
    int                                 accesses;
    int                                 ignored;
    int                                 checked;

    function new();
      reg_set_bits   = sac_pkg::SET_BITS_RST;
      reg_block_bits = sac_pkg::BLOCK_BITS_RST;
      reg_ways       = sac_pkg::WAYS_RST;
      foreach (way_used[i]) begin
        way_used[i] = 1'b0;
        way_tag[i]  = '0;
        way_rank[i] = 0;
      end
      hit_total   = '0;
      miss_total  = '0;
      evict_total = '0;
      errors      = 0;
      accesses    = 0;
      ignored     = 0;
      checked     = 0;
    endfunction

    function int eff_set_bits();
      return (reg_set_bits > sac_pkg::MAX_SET_BITS_DEF) ? sac_pkg::MAX_SET_BITS_DEF :
             int'(reg_set_bits);
    endfunction

    function int eff_ways();
      if (reg_ways == 0) return 1;
      if (reg_ways > sac_pkg::MAX_WAYS_DEF) return sac_pkg::MAX_WAYS_DEF;
      return int'(reg_ways);
    endfunction

    function logic [sac_pkg::CNT_W-1:0] bump(logic [sac_pkg::CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void apply_reg(logic [sac_pkg::CFG_IDX_W-1:0] idx,
                            logic [sac_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sac_pkg::REG_SET_BITS: reg_set_bits = val[sac_pkg::SET_BITS_W-1:0];
        sac_pkg::REG_BLOCK_BITS: reg_block_bits = val[sac_pkg::BLK_BITS_W-1:0];
        sac_pkg::REG_WAYS: reg_ways = val[sac_pkg::WAYS_W-1:0];
        default: ;
      endcase
    endfunction

    function void probe_set(int set_idx, logic [31:0] tagv, logic is_last);
      int n, base, victim, prior, oldest, k;
      bit found, hit_now, ev;
      outcome_t rec;
      n = eff_ways();
      base = set_idx * sac_pkg::MAX_WAYS_DEF;
      found = 1'b0;
      hit_now = 1'b0;
      ev = 1'b0;
      victim = 0;
      for (k = 0; k < n; k++)
        if (!found && way_used[base+k] && way_tag[base+k] == tagv) begin
          victim = k;
          found = 1'b1;
        end
      if (found) begin
        hit_now = 1'b1;
        hit_total = bump(hit_total);
      end else begin
        miss_total = bump(miss_total);
        for (k = 0; k < n; k++)
          if (!found && !way_used[base+k]) begin
            victim = k;
            found = 1'b1;
          end
        if (!found) begin
          oldest = 0;
          for (k = 0; k < n; k++)
            if (way_rank[base+k] > oldest) begin
              oldest = way_rank[base+k];
              victim = k;
            end
          ev = 1'b1;
          evict_total = bump(evict_total);
        end
      end
      // invalid victim counts as older than every valid way
      prior = way_used[base+victim] ? way_rank[base+victim] : AGE_TOP + 1;
      for (k = 0; k < n; k++)
        if (k != victim && way_used[base+k] && way_rank[base+k] < prior &&
            way_rank[base+k] < AGE_TOP)
          way_rank[base+k]++;
      way_used[base+victim] = 1'b1;
      way_tag[base+victim]  = tagv;
      way_rank[base+victim] = 0;
      rec.hit       = hit_now;
      rec.evicted   = ev;
      rec.last      = is_last;
      rec.hits      = hit_total;
      rec.misses    = miss_total;
      rec.evictions = evict_total;
      awaited.push_back(rec);
    endfunction

    function void note_access(logic [ACT_W-1:0] act, logic [31:0] addr);
      int sbe, bbv, set_idx;
      logic [31:0] tagv;
      if (act == sac_pkg::ACT_NONE) begin
        ignored++;
        return;
      end
      accesses++;
      sbe = eff_set_bits();
      bbv = int'(reg_block_bits);
      set_idx = int'((addr >> bbv) & ((32'd1 << sbe) - 1));
      tagv = (sbe + bbv >= 32) ? '0 : (addr >> (sbe + bbv));
      if (act == sac_pkg::ACT_MODIFY) begin
        probe_set(set_idx, tagv, 1'b0);
        probe_set(set_idx, tagv, 1'b1);
      end else begin
        probe_set(set_idx, tagv, 1'b1);
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, none pending: hit=%0b ev=%0b last=%0b",
                 $time, got.hit, got.evicted, got.last);
        $display("%0t:   h=%0d m=%0d e=%0d", $time, got.hits, got.misses, got.evictions);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.hit !== want.hit || got.evicted !== want.evicted || got.last !== want.last ||
          got.hits !== want.hits || got.misses !== want.misses ||
          got.evictions !== want.evictions) begin
        errors++;
        $display("%0t: exp hit=%0b ev=%0b last=%0b h=%0d m=%0d e=%0d",
                 $time, want.hit, want.evicted, want.last, want.hits, want.misses,
                 want.evictions);
        $display("%0t: got hit=%0b ev=%0b last=%0b h=%0d m=%0d e=%0d",
                 $time, got.hit, got.evicted, got.last, got.hits, got.misses,
                 got.evictions);
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [ACT_W-1:0]                  action;
  logic [31:0]                       address;
  logic                              out_valid;
  logic                              out_ready;
  logic                              hit;
  logic                              evicted;
  logic                              last;
  logic [sac_pkg::CNT_W-1:0]         hits_total;
  logic [sac_pkg::CNT_W-1:0]         misses_total;
  logic [sac_pkg::CNT_W-1:0]         evictions_total;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [sac_pkg::CFG_DATA_W-1:0]    cfg_data;

  cache_scoreboard board;
  bit              hold_req = 1'b0;
  int              hold_left = 0;
  int              rx_cycle = 0;
  rx_style_t       rx_mode = RX_STEADY;

  logic [sac_pkg::CFG_DATA_W-1:0] ph_set_bits[PHASES] =
    '{5'd2, 5'd0, 5'd6, 5'd15, 5'd3, 5'd1, 5'd5, 5'd4, 5'd6, 5'd2};
  logic [sac_pkg::CFG_DATA_W-1:0] ph_block_bits[PHASES] =
    '{5'd4, 5'd0, 5'd26, 5'd31, 5'd5, 5'd2, 5'd8, 5'd3, 5'd0, 5'd10};
  logic [sac_pkg::CFG_DATA_W-1:0] ph_ways[PHASES] =
    '{5'd4, 5'd8, 5'd8, 5'd15, 5'd0, 5'd3, 5'd6, 5'd2, 5'd8, 5'd5};

  set_assoc_lru_cache_sim DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .address         (address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hit             (hit),
    .evicted         (evicted),
    .last            (last),
    .hits_total      (hits_total),
    .misses_total    (misses_total),
    .evictions_total (evictions_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    outcome_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.hit       = hit;
        seen.evicted   = evicted;
        seen.last      = last;
        seen.hits      = hits_total;
        seen.misses    = misses_total;
        seen.evictions = evictions_total;
        board.check_result(seen);
      end
      if (in_valid && in_ready) board.note_access(action, address);
      if (cfg_valid && cfg_ready) board.apply_reg(cfg_index, cfg_data);
    end
  end

  // result side backpressure; one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_mode = rx_style_t'($urandom_range(0, 3));
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: out_ready <= (rx_cycle % 5) != 0;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_access(logic [ACT_W-1:0] act, logic [31:0] addr);
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= act;
    address  <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [sac_pkg::CFG_IDX_W-1:0] idx,
                           logic [sac_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly addresses that land on a few sets with a small tag pool, some pure noise
  function automatic void pick_access(output logic [ACT_W-1:0] act, output logic [31:0] addr);
    int sbe, bbv, nw, lim;
    logic [31:0] tagv, setv;
    logic [63:0] offv, full;
    int r;
    r = $urandom_range(0, 19);
    act = (r == 0) ? sac_pkg::ACT_NONE : ACT_W'(r % 3);
    sbe = board.eff_set_bits();
    bbv = int'(board.reg_block_bits);
    nw  = board.eff_ways();
    lim = (1 << sbe) - 1;
    if ($urandom_range(0, 9) == 0) begin
      addr = $urandom;
    end else begin
      tagv = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, nw + 1);
      setv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim) : ($urandom_range(0, 3) & lim);
      offv = 64'($urandom) & ((64'd1 << bbv) - 1);
      full = (64'(tagv) << (sbe + bbv)) | (64'(setv) << bbv) | offv;
      addr = full[31:0];
    end
  endfunction

  initial begin
    logic [ACT_W-1:0] act;
    logic [31:0] addr;
    int burst, sent, p;
    bit gaps_on;
    board     = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = sac_pkg::ACT_LOAD;
    address   = '0;
    cfg_valid = 1'b0;
    cfg_index = sac_pkg::REG_SET_BITS;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry: one set, one way
    send_access(sac_pkg::ACT_NONE, 32'h0000_0000);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0000);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_000F);
    send_access(sac_pkg::ACT_STORE, 32'hFFFF_FFFF);
    send_access(sac_pkg::ACT_MODIFY, 32'hFFFF_FFF0);
    send_access(sac_pkg::ACT_MODIFY, 32'h0000_0010);

    settle_block();
    write_reg(sac_pkg::REG_SET_BITS, 5'd1);
    write_reg(sac_pkg::REG_WAYS, 5'd2);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0000);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0020);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0000);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0040);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0020);
    send_access(sac_pkg::ACT_STORE, 32'h0000_0010);
    send_access(sac_pkg::ACT_NONE, 32'hFFFF_FFFF);
    send_access(sac_pkg::ACT_MODIFY, 32'h0000_0050);

    // oversized set_bits and ways, set plus offset bits beyond the address width
    settle_block();
    write_reg(sac_pkg::REG_SET_BITS, 5'd15);
    write_reg(sac_pkg::REG_BLOCK_BITS, 5'd31);
    write_reg(sac_pkg::REG_WAYS, 5'd15);
    send_access(sac_pkg::ACT_LOAD, 32'h8000_0000);
    send_access(sac_pkg::ACT_LOAD, 32'h7FFF_FFFF);
    send_access(sac_pkg::ACT_MODIFY, 32'h8000_0000);

    settle_block();
    write_reg(sac_pkg::REG_BLOCK_BITS, 5'd26);
    send_access(sac_pkg::ACT_LOAD, 32'hFC00_0000);
    send_access(sac_pkg::ACT_STORE, 32'h0400_0000);

    // zero ways acts as one; lines from earlier geometries stay valid
    settle_block();
    write_reg(sac_pkg::REG_WAYS, 5'd0);
    write_reg(sac_pkg::REG_BLOCK_BITS, 5'd0);
    write_reg(sac_pkg::REG_SET_BITS, 5'd0);
    write_reg(REG_UNUSED, 5'h1F);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0001);
    send_access(sac_pkg::ACT_LOAD, 32'h0000_0002);
    send_access(sac_pkg::ACT_MODIFY, 32'h0000_0001);

    for (p = 0; p < PHASES; p++) begin
      settle_block();
      write_reg(sac_pkg::REG_SET_BITS, ph_set_bits[p]);
      write_reg(sac_pkg::REG_BLOCK_BITS, ph_block_bits[p]);
      write_reg(sac_pkg::REG_WAYS, ph_ways[p]);
      if (p == 2) hold_req = 1'b1;
      gaps_on = (p % 3) != 1;
      sent = 0;
      burst = $urandom_range(1, 24);
      while (sent < PHASE_ITEMS) begin
        pick_access(act, addr);
        send_access(act, addr);
        if (act != sac_pkg::ACT_NONE) sent++;
        burst--;
        if (burst == 0) begin
          if (gaps_on) pause_input($urandom_range(1, 8));
          burst = $urandom_range(1, 24);
        end
      end
    end

    settle_block();
    repeat (12) @(posedge clk);
    $display("Covered %0d accesses and %0d ignored codes over %0d geometries, %0d lookups checked",
             board.accesses, board.ignored, PHASES + 5, board.checked);
    $display("Predicted totals: %0d hits, %0d misses, %0d evictions",
             board.hit_total, board.miss_total, board.evict_total);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("set_assoc_lru_cache_sim: match");
    end else begin
      $display("set_assoc_lru_cache_sim: mismatch");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results outstanding", board.pending());
    $display("set_assoc_lru_cache_sim: mismatch");
    $finish;
  end

endmodule
